// ===== hw/rtl/snapshot_history_ring_macros.svh =====
// Assertion macros for the snapshot history ring RTL.
`ifndef SNAPSHOT_HISTORY_RING_MACROS_SVH
`define SNAPSHOT_HISTORY_RING_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define SHR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition that must never hold outside reset.
`define SHR_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/shr_pkg.sv =====
// Types and constants shared by the snapshot history ring modules.
package shr_pkg;

    localparam int OP_W        = 3;
    localparam int DATA_W      = 32;
    localparam int POS_W       = 4;
    localparam int SLOT_OUT_W  = 4;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 3'd0,
        OP_OPEN  = 3'd1,
        OP_CLOSE = 3'd2,
        OP_NTH   = 3'd3,
        OP_FIND  = 3'd4,
        OP_READ  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_DONE
    } seq_state_t;

    // Record memory controls.
    typedef struct packed {
        logic wr_frame;
        logic wr_crc_seed;
        logic rd_en;
    } mem_ctl_t;

    // Result header handed to the output register.
    typedef struct packed {
        logic                   found;
        logic [SLOT_OUT_W-1:0]  slot_number;
        logic [COUNT_OUT_W-1:0] valid_count;
    } res_t;

endpackage

// ===== hw/rtl/shr_record_mem.sv =====
// Record storage: frame memory and checksum/seed memory, one read port each.
module shr_record_mem
    import shr_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  mem_ctl_t          ctl,
    input  logic [AW-1:0]     wr_addr,
    input  logic [AW-1:0]     rd_addr,
    input  logic [DATA_W-1:0] wr_frame,
    input  logic [DATA_W-1:0] wr_crc,
    input  logic [DATA_W-1:0] wr_seed,
    output logic [DATA_W-1:0] rd_frame,
    output logic [DATA_W-1:0] rd_crc,
    output logic [DATA_W-1:0] rd_seed
);

    logic [DATA_W-1:0]   frame_mem [DEPTH];
    logic [2*DATA_W-1:0] cs_mem    [DEPTH];

    logic [DATA_W-1:0]   rd_frame_reg;
    logic [2*DATA_W-1:0] rd_cs_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_frame) begin
            frame_mem[wr_addr] <= wr_frame;
        end
        if (ctl.wr_crc_seed) begin
            cs_mem[wr_addr] <= {wr_crc, wr_seed};
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_frame_reg <= frame_mem[rd_addr];
            rd_cs_reg    <= cs_mem[rd_addr];
        end
    end

    assign rd_frame = rd_frame_reg;
    assign rd_crc   = rd_cs_reg[2*DATA_W-1:DATA_W];
    assign rd_seed  = rd_cs_reg[DATA_W-1:0];

endmodule

// ===== hw/rtl/shr_ctrl.sv =====
// Request sequencer: valid marks, write slot, count, newest pointer, key search.
`include "snapshot_history_ring_macros.svh"

module shr_ctrl
    import shr_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int SW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [OP_W-1:0]   op,
    input  logic [DATA_W-1:0] key,
    input  logic [POS_W-1:0]  pos,
    input  logic              out_free,
    input  logic [DATA_W-1:0] rd_crc,
    output mem_ctl_t          mem_ctl,
    output logic [SW-1:0]     wr_addr,
    output logic [SW-1:0]     rd_addr,
    output logic              res_load,
    output res_t              res
);

    localparam int EW = SW + POS_W + 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(DEPTH - 1);

    seq_state_t        state_reg, state_next;
    logic [SW-1:0]     ws_reg, ws_next;
    logic              open_reg, open_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [DEPTH-1:0]  valid_reg, valid_next;
    logic [SW-1:0]     newest_reg, newest_next;
    logic [SW-1:0]     cur_reg, cur_next;
    logic [CW-1:0]     left_reg, left_next;
    logic              pend_reg, pend_next;
    logic [SW-1:0]     pend_slot_reg, pend_slot_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic              found_reg, found_next;
    logic [SW-1:0]     slot_reg, slot_next;

    logic [SW-1:0]     ws_inc, ws_open, cur_dec, nth_slot;
    logic [EW-1:0]     pos_ext, count_ext, nth_sum, nth_wrap;
    logic              nth_hit, read_hit, match;
    logic [SW+3:0]     slot_x;
    logic [CW+4:0]     count_x;

    assign ws_inc    = (ws_reg == LAST_SLOT) ? '0 : ws_reg + 1'b1;
    assign ws_open   = open_reg ? ws_inc : '0;
    assign cur_dec   = (cur_reg == '0) ? LAST_SLOT : cur_reg - 1'b1;
    assign pos_ext   = EW'(pos);
    assign count_ext = EW'(count_reg);
    // n-th newest lies n slots behind the newest, modulo the ring depth
    assign nth_sum   = EW'(newest_reg) + EW'(DEPTH) - pos_ext;
    assign nth_wrap  = (nth_sum >= EW'(DEPTH)) ? nth_sum - EW'(DEPTH) : nth_sum;
    assign nth_slot  = nth_wrap[SW-1:0];
    assign nth_hit   = (pos_ext < count_ext) && valid_reg[nth_slot];
    assign read_hit  = (pos_ext < EW'(DEPTH)) && valid_reg[pos_ext[SW-1:0]];
    assign match     = pend_reg && (rd_crc == key_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ws_reg    <= '0;
            open_reg  <= 1'b0;
            count_reg <= '0;
            valid_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ws_reg    <= ws_next;
            open_reg  <= open_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        newest_reg    <= newest_next;
        cur_reg       <= cur_next;
        left_reg      <= left_next;
        pend_slot_reg <= pend_slot_next;
        key_reg       <= key_next;
        found_reg     <= found_next;
        slot_reg      <= slot_next;
    end

    always_comb begin
        state_next     = state_reg;
        ws_next        = ws_reg;
        open_next      = open_reg;
        count_next     = count_reg;
        valid_next     = valid_reg;
        newest_next    = newest_reg;
        cur_next       = cur_reg;
        left_next      = left_reg;
        pend_next      = pend_reg;
        pend_slot_next = pend_slot_reg;
        key_next       = key_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        mem_ctl        = '0;
        wr_addr        = ws_reg;
        rd_addr        = cur_reg;
        res_load       = 1'b0;
        req_ready      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    state_next = ST_DONE;
                    found_next = 1'b0;
                    case (op_t'(op))
                        OP_CLEAR: begin
                            valid_next = '0;
                            ws_next    = '0;
                            open_next  = 1'b0;
                            count_next = '0;
                        end
                        OP_OPEN: begin
                            ws_next             = ws_open;
                            open_next           = 1'b1;
                            mem_ctl.wr_frame    = 1'b1;
                            wr_addr             = ws_open;
                            valid_next[ws_open] = 1'b0;
                            if (valid_reg[ws_open] && count_reg != '0) begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_CLOSE: begin
                            if (open_reg) begin
                                mem_ctl.wr_crc_seed = 1'b1;
                                newest_next         = ws_reg;
                                if (!valid_reg[ws_reg]) begin
                                    valid_next[ws_reg] = 1'b1;
                                    if (count_reg < CW'(DEPTH)) begin
                                        count_next = count_reg + 1'b1;
                                    end
                                end
                            end
                        end
                        OP_NTH: begin
                            found_next     = nth_hit;
                            slot_next      = nth_slot;
                            mem_ctl.rd_en  = nth_hit;
                            rd_addr        = nth_slot;
                        end
                        OP_FIND: begin
                            key_next = key;
                            if (count_reg != '0) begin
                                cur_next   = newest_reg;
                                left_next  = count_reg;
                                pend_next  = 1'b0;
                                state_next = ST_FIND;
                            end
                        end
                        OP_READ: begin
                            found_next    = read_hit;
                            slot_next     = pos_ext[SW-1:0];
                            mem_ctl.rd_en = read_hit;
                            rd_addr       = pos_ext[SW-1:0];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FIND: begin
                // one slot read per cycle; each read is compared in the cycle after it
                if (match) begin
                    found_next = 1'b1;
                    slot_next  = pend_slot_reg;
                    pend_next  = 1'b0;
                    state_next = ST_DONE;
                end else if (left_reg != '0) begin
                    mem_ctl.rd_en  = valid_reg[cur_reg];
                    rd_addr        = cur_reg;
                    pend_next      = valid_reg[cur_reg];
                    pend_slot_next = cur_reg;
                    cur_next       = cur_dec;
                    left_next      = left_reg - 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign slot_x  = (SW + 4)'(slot_reg);
    assign count_x = (CW + 5)'(count_reg);

    assign res.found       = found_reg;
    assign res.slot_number = found_reg ? slot_x[SLOT_OUT_W-1:0] : '0;
    assign res.valid_count = count_x[COUNT_OUT_W-1:0];

    `SHR_ASSERT(a_count_matches_marks, count_reg == CW'($countones(valid_reg)), "count out of step with valid marks")
    `SHR_ASSERT(a_newest_is_valid, (count_reg != '0) |-> valid_reg[newest_reg], "newest pointer names an invalid slot")
    `SHR_ASSERT(a_found_is_valid, (state_reg == ST_DONE && found_reg) |-> valid_reg[slot_reg], "result names an invalid slot")
    `SHR_ASSERT_NEVER(a_load_when_full, res_load && !out_free, "result loaded over a pending result")

endmodule

// ===== hw/rtl/snapshot_history_ring.sv =====
// Snapshot history ring top level: sequencer, record memory and result register.
//
// Usage:
//   Requests enter on the s_ channel (valid/ready): s_op selects clear, open
//   record, close record, n-th newest, find checksum or read slot. Every request
//   yields exactly one result on the m_ channel (valid/ready) carrying found,
//   slot, frame, checksum, seed and the complete-record count after the request.
//   Requests are handled one at a time. For all operations but find, the
//   sequencer moves from idle to its done state on acceptance; find walks
//   back from the newest complete record one slot per cycle through the
//   checksum memory port before it reaches the done state. From there the
//   result enters the output register once that register is free. The next
//   request is accepted as soon as the previous result is in the output
//   register, even while that result still waits for m_ready.
//   A stalled receiver holds the result in place; once a second result is
//   finished it waits inside the sequencer and s_ready stays low.
//   Reset clears the valid marks, write slot, count and handshakes at once;
//   record memory contents are never read unless marked valid.
module snapshot_history_ring
    import shr_pkg::*;
#(
    parameter int RING_DEPTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OP_W-1:0]        s_op,
    input  logic [DATA_W-1:0]      s_frame_number,
    input  logic [DATA_W-1:0]      s_crc_value,
    input  logic [DATA_W-1:0]      s_seed_value,
    input  logic [POS_W-1:0]       s_position,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_found,
    output logic [SLOT_OUT_W-1:0]  m_slot_number,
    output logic [DATA_W-1:0]      m_rec_frame,
    output logic [DATA_W-1:0]      m_rec_crc,
    output logic [DATA_W-1:0]      m_rec_seed,
    output logic [COUNT_OUT_W-1:0] m_valid_count
);

    localparam int SW = $clog2(RING_DEPTH);

    mem_ctl_t          mem_ctl;
    logic [SW-1:0]     wr_addr;
    logic [SW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_frame;
    logic [DATA_W-1:0] rd_crc;
    logic [DATA_W-1:0] rd_seed;
    logic              res_load;
    res_t              res;
    logic              out_free;

    logic                   m_valid_reg;
    logic                   m_found_reg;
    logic [SLOT_OUT_W-1:0]  m_slot_reg;
    logic [DATA_W-1:0]      m_frame_reg;
    logic [DATA_W-1:0]      m_crc_reg;
    logic [DATA_W-1:0]      m_seed_reg;
    logic [COUNT_OUT_W-1:0] m_count_reg;

    // output register is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    shr_ctrl #(
        .DEPTH (RING_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .op        (s_op),
        .key       (s_crc_value),
        .pos       (s_position),
        .out_free  (out_free),
        .rd_crc    (rd_crc),
        .mem_ctl   (mem_ctl),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr),
        .res_load  (res_load),
        .res       (res)
    );

    shr_record_mem #(
        .DEPTH (RING_DEPTH)
    ) u_mem (
        .aclk     (aclk),
        .ctl      (mem_ctl),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .wr_frame (s_frame_number),
        .wr_crc   (s_crc_value),
        .wr_seed  (s_seed_value),
        .rd_frame (rd_frame),
        .rd_crc   (rd_crc),
        .rd_seed  (rd_seed)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // record fields read as zero on a miss
    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_found_reg <= res.found;
            m_slot_reg  <= res.slot_number;
            m_frame_reg <= res.found ? rd_frame : '0;
            m_crc_reg   <= res.found ? rd_crc : '0;
            m_seed_reg  <= res.found ? rd_seed : '0;
            m_count_reg <= res.valid_count;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_slot_number = m_slot_reg;
    assign m_rec_frame   = m_frame_reg;
    assign m_rec_crc     = m_crc_reg;
    assign m_rec_seed    = m_seed_reg;
    assign m_valid_count = m_count_reg;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the snapshot history ring: directed and random requests.
module testbench;
    import shr_pkg::*;

    // Ring size under test; the predictor uses the same value.
    localparam int RING_SLOTS = 16;

    // Op codes the package leaves unnamed: the block must treat them as no-ops.
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    // Run length and safety limits.
    localparam int RANDOM_ITEMS  = 1400;
    localparam int DRAIN_EVERY   = 250;   // random requests between forced drains
    localparam int SETTLE_CYCLES = 40;    // worst find walk plus margin
    localparam int STALL_LIMIT   = 2000;  // cycles with no handshake on either side

    // Receiver stall patterns.
    localparam int RDY_FREE     = 0;
    localparam int RDY_COIN     = 1;
    localparam int RDY_SPARSE   = 2;
    localparam int RDY_PERIODIC = 3;

    // One result as it leaves the block.
    typedef struct packed {
        logic                   found;
        logic [SLOT_OUT_W-1:0]  slot_number;
        logic [DATA_W-1:0]      rec_frame;
        logic [DATA_W-1:0]      rec_crc;
        logic [DATA_W-1:0]      rec_seed;
        logic [COUNT_OUT_W-1:0] valid_count;
    } ring_result_t;

    // Tracks the ring contents, predicts each result and checks it on arrival.
    class snapshot_ring_tracker;
        logic [DATA_W-1:0] frame_mem[RING_SLOTS];
        logic [DATA_W-1:0] crc_mem[RING_SLOTS];
        logic [DATA_W-1:0] seed_mem[RING_SLOTS];
        bit                marks[RING_SLOTS];
        int unsigned       wr_slot;
        bit                any_open;
        int unsigned       complete;
        ring_result_t      pending_results[$];
        int unsigned       errors;
        int unsigned       hits;
        int unsigned       full_ring_seen;
        int unsigned       op_tally[8];

        function new();
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < RING_SLOTS; i++) begin
                frame_mem[i] = '0;
                crc_mem[i]   = '0;
                seed_mem[i]  = '0;
                marks[i]     = 1'b0;
            end
            wr_slot  = 0;
            any_open = 1'b0;
            complete = 0;
        endfunction

        // Newest complete slot, searching back from the write slot; -1 if none.
        function int newest_complete();
            int unsigned s;
            if (!any_open)
                return -1;
            for (int k = 0; k < RING_SLOTS; k++) begin
                s = (wr_slot + RING_SLOTS - k) % RING_SLOTS;
                if (marks[s])
                    return s;
            end
            return -1;
        endfunction

        // Plain step back from the newest; a hole in the ring is a miss, not skipped.
        function int nth_complete(int unsigned age);
            int nw;
            int unsigned s;
            nw = newest_complete();
            if (nw < 0 || age >= complete)
                return -1;
            s = (nw + RING_SLOTS - (age % RING_SLOTS)) % RING_SLOTS;
            return marks[s] ? int'(s) : -1;
        endfunction

        function int find_by_crc(logic [DATA_W-1:0] key);
            int s;
            for (int unsigned n = 0; n < complete && n < RING_SLOTS; n++) begin
                s = nth_complete(n);
                if (s >= 0 && crc_mem[s] == key)
                    return s;
            end
            return -1;
        endfunction

        function void log_request(logic [OP_W-1:0] code, logic [DATA_W-1:0] frame,
                                  logic [DATA_W-1:0] crc, logic [DATA_W-1:0] seed,
                                  logic [POS_W-1:0] pos);
            int           hit;
            ring_result_t r;
            hit = -1;
            op_tally[code]++;
            case (code)
                OP_CLEAR: begin
                    wipe();
                end
                OP_OPEN: begin
                    wr_slot  = any_open ? (wr_slot + 1) % RING_SLOTS : 0;
                    any_open = 1'b1;
                    if (marks[wr_slot] && complete > 0)
                        complete--;
                    frame_mem[wr_slot] = frame;
                    crc_mem[wr_slot]   = '0;
                    seed_mem[wr_slot]  = '0;
                    marks[wr_slot]     = 1'b0;
                end
                OP_CLOSE: begin
                    if (any_open) begin
                        crc_mem[wr_slot]  = crc;
                        seed_mem[wr_slot] = seed;
                        if (!marks[wr_slot]) begin
                            marks[wr_slot] = 1'b1;
                            if (complete < RING_SLOTS)
                                complete++;
                            if (complete == RING_SLOTS)
                                full_ring_seen++;
                        end
                    end
                end
                OP_NTH:  hit = nth_complete(32'(pos));
                OP_FIND: hit = find_by_crc(crc);
                OP_READ: begin
                    if (pos < RING_SLOTS && marks[pos % RING_SLOTS])
                        hit = 32'(pos);
                end
                default: ;
            endcase
            r = '0;
            if (hit >= 0) begin
                hits++;
                r.found       = 1'b1;
                r.slot_number = hit[SLOT_OUT_W-1:0];
                r.rec_frame   = frame_mem[hit];
                r.rec_crc     = crc_mem[hit];
                r.rec_seed    = seed_mem[hit];
            end
            r.valid_count = complete[COUNT_OUT_W-1:0];
            pending_results = {pending_results, r};
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic f, logic [SLOT_OUT_W-1:0] slot,
                                   logic [DATA_W-1:0] frame, logic [DATA_W-1:0] crc,
                                   logic [DATA_W-1:0] seed, logic [COUNT_OUT_W-1:0] cnt);
            ring_result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: expected none, actual found=%0d slot=%0d count=%0d",
                         $time, f, slot, cnt);
                return;
            end
            want = pending_results.pop_front();
            compare_field("found", DATA_W'(want.found), DATA_W'(f));
            compare_field("slot_number", DATA_W'(want.slot_number), DATA_W'(slot));
            compare_field("rec_frame", want.rec_frame, frame);
            compare_field("rec_crc", want.rec_crc, crc);
            compare_field("rec_seed", want.rec_seed, seed);
            compare_field("valid_count", DATA_W'(want.valid_count), DATA_W'(cnt));
        endfunction
    endclass

    // Every block input starts at a known value.
    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   s_valid        = 1'b0;
    logic [OP_W-1:0]        s_op           = '0;
    logic [DATA_W-1:0]      s_frame_number = '0;
    logic [DATA_W-1:0]      s_crc_value    = '0;
    logic [DATA_W-1:0]      s_seed_value   = '0;
    logic [POS_W-1:0]       s_position     = '0;
    logic                   m_ready        = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    logic                   m_found;
    logic [SLOT_OUT_W-1:0]  m_slot_number;
    logic [DATA_W-1:0]      m_rec_frame;
    logic [DATA_W-1:0]      m_rec_crc;
    logic [DATA_W-1:0]      m_rec_seed;
    logic [COUNT_OUT_W-1:0] m_valid_count;

    snapshot_ring_tracker tracker = new();

    // Sender pacing: bursts of requests separated by idle gaps.
    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned next_drain  = 0;
    logic [DATA_W-1:0] crc_pool[$];   // recent close checksums, reused as find keys

    // Receiver pattern state and watchdog.
    int unsigned ready_mode  = RDY_FREE;
    int unsigned mode_left   = 0;
    int unsigned rx_cycle    = 0;
    int unsigned idle_cycles = 0;

    snapshot_history_ring #(.RING_DEPTH(RING_SLOTS)) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_frame_number (s_frame_number),
        .s_crc_value    (s_crc_value),
        .s_seed_value   (s_seed_value),
        .s_position     (s_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_slot_number  (m_slot_number),
        .m_rec_frame    (m_rec_frame),
        .m_rec_crc      (m_rec_crc),
        .m_rec_seed     (m_rec_seed),
        .m_valid_count  (m_valid_count)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Sender idling. Lowers valid at most once per step and always waits out a
    // random idle gap before the next request raises it again. With drain
    // set it also holds off until every outstanding result has come back.
    task automatic pace_sender(input bit drain);
        int unsigned gap;
        if (burst_left > 0)
            burst_left--;
        if (!drain && burst_left > 0)
            return;
        s_valid <= 1'b0;
        // Mostly short gaps; now and then a long quiet stretch.
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
        repeat (gap) @(posedge aclk);
        if (drain) begin
            while (tracker.pending_results.size() != 0)
                @(posedge aclk);
        end
        // Some bursts are long enough to run with no idling at all.
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
    endtask

    // Present one request, hold it until the handshake, then log it.
    task automatic issue(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] frame,
                         input logic [DATA_W-1:0] crc, input logic [DATA_W-1:0] seed,
                         input int unsigned pos);
        s_valid        <= 1'b1;
        s_op           <= code;
        s_frame_number <= frame;
        s_crc_value    <= crc;
        s_seed_value   <= seed;
        s_position     <= POS_W'(pos);
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        tracker.log_request(code, frame, crc, seed, POS_W'(pos));
        items_sent++;
        if (code == OP_CLOSE) begin
            crc_pool = {crc_pool, crc};
            if (crc_pool.size() > 24)
                void'(crc_pool.pop_front());
        end
        pace_sender(1'b0);
    endtask

    // Checksum for close or find: recent values so finds hit and duplicate keys
    // appear, the extremes, or anything at all.
    function automatic logic [DATA_W-1:0] pick_crc();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 4 && crc_pool.size() > 0)
            return crc_pool[$urandom_range(0, crc_pool.size() - 1)];
        if (roll == 4)
            return '0;
        if (roll == 5)
            return '1;
        return $urandom;
    endfunction

    // Receiver: check every accepted result, then choose next cycle's ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_result(m_found, m_slot_number, m_rec_frame, m_rec_crc,
                                 m_rec_seed, m_valid_count);
        rx_cycle++;
        if (mode_left == 0) begin
            ready_mode = $urandom_range(RDY_FREE, RDY_PERIODIC);
            mode_left  = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            RDY_FREE:   m_ready <= 1'b1;
            RDY_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
            RDY_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
            default:    m_ready <= (rx_cycle % 16 == 0);
        endcase
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog: nothing moved for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, tracker.pending_results.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int unsigned pick;
        int unsigned random_target;

        // Synchronous reset, held at the start and never again.
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- Directed: empty ring, stray close, unused codes ---
        issue(OP_NTH,   $urandom, $urandom, $urandom, 0);
        issue(OP_FIND,  $urandom, 32'h0, $urandom, $urandom);
        issue(OP_READ,  $urandom, $urandom, $urandom, 15);
        issue(OP_CLOSE, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom);
        issue(OP_SPARE_A, $urandom, $urandom, $urandom, $urandom);
        issue(OP_SPARE_B, $urandom, $urandom, $urandom, $urandom);

        // First open lands in slot 0; an open but incomplete record is not found.
        issue(OP_OPEN,  32'h0, $urandom, $urandom, $urandom);
        issue(OP_NTH,   $urandom, $urandom, $urandom, 0);
        issue(OP_READ,  $urandom, $urandom, $urandom, 0);

        // Close, then close the same slot again: data replaced, count unchanged.
        issue(OP_CLOSE, $urandom, 32'hFFFF_FFFF, 32'h0, $urandom);
        issue(OP_CLOSE, $urandom, 32'h0, 32'hFFFF_FFFF, $urandom);

        issue(OP_OPEN,  32'hFFFF_FFFF, $urandom, $urandom, $urandom);
        issue(OP_CLOSE, $urandom, 32'h1234_5678, 32'h8765_4321, $urandom);

        // Ages in range, at the count, and past it.
        issue(OP_NTH,   $urandom, $urandom, $urandom, 0);
        issue(OP_NTH,   $urandom, $urandom, $urandom, 1);
        issue(OP_NTH,   $urandom, $urandom, $urandom, 2);
        issue(OP_NTH,   $urandom, $urandom, $urandom, 15);

        // Finds: hit on the replaced key, hit on the newer one, and a miss.
        issue(OP_FIND,  $urandom, 32'h0, $urandom, $urandom);
        issue(OP_FIND,  $urandom, 32'h1234_5678, $urandom, $urandom);
        issue(OP_FIND,  $urandom, 32'hFFFF_FFFF, $urandom, $urandom);

        issue(OP_READ,  $urandom, $urandom, $urandom, 1);
        issue(OP_READ,  $urandom, $urandom, $urandom, 15);

        // Clear wipes everything; a close right after is ignored.
        issue(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
        issue(OP_READ,  $urandom, $urandom, $urandom, 0);
        issue(OP_CLOSE, $urandom, $urandom, $urandom, $urandom);

        // Hold off until the directed results are all back.
        pace_sender(1'b1);

        // --- Random: mostly open/close pairs with queries mixed in ---
        random_target = items_sent + RANDOM_ITEMS;
        next_drain    = items_sent + DRAIN_EVERY;
        while (items_sent < random_target) begin
            pick = $urandom_range(0, 99);
            if (pick < 1) begin
                issue(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
            end else if (pick < 3) begin
                issue($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B,
                      $urandom, $urandom, $urandom, $urandom);
            end else if (pick < 7) begin
                // Stray or repeated close.
                issue(OP_CLOSE, $urandom, pick_crc(), $urandom, $urandom);
            end else if (pick < 15) begin
                issue(OP_NTH, $urandom, $urandom, $urandom, $urandom_range(0, 15));
            end else if (pick < 24) begin
                issue(OP_FIND, $urandom, pick_crc(), $urandom, $urandom);
            end else if (pick < 29) begin
                issue(OP_READ, $urandom, $urandom, $urandom, $urandom_range(0, 15));
            end else begin
                // Well-formed record; sometimes left open to punch a hole in the ring.
                issue(OP_OPEN, $urandom, $urandom, $urandom, $urandom);
                if ($urandom_range(0, 9) != 0) begin
                    if ($urandom_range(0, 5) == 0)
                        issue(OP_NTH, $urandom, $urandom, $urandom, $urandom_range(0, 3));
                    issue(OP_CLOSE, $urandom, pick_crc(), $urandom, $urandom);
                end
            end
            if (items_sent >= next_drain) begin
                pace_sender(1'b1);
                next_drain = items_sent + DRAIN_EVERY;
            end
        end

        // Let everything come back, then watch for stray results.
        pace_sender(1'b1);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("run covered %0d requests: %0d opens, %0d closes, %0d nth, %0d finds, %0d reads, %0d clears, %0d unused codes",
                 items_sent, tracker.op_tally[OP_OPEN], tracker.op_tally[OP_CLOSE],
                 tracker.op_tally[OP_NTH], tracker.op_tally[OP_FIND],
                 tracker.op_tally[OP_READ], tracker.op_tally[OP_CLEAR],
                 tracker.op_tally[OP_SPARE_A] + tracker.op_tally[OP_SPARE_B]);
        $display("%0d queries hit a record; ring filled to %0d records %0d times",
                 tracker.hits, RING_SLOTS, tracker.full_ring_seen);

        if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
